FILE: src/tkqb_pkg.sv
// tkqb_pkg: command codes, register indexes, defaults and divisibility helpers
// for the tick / key qualifier / buzzer block.
// No dependencies.
package tkqb_pkg;

  localparam int unsigned NUM_BUTTONS_DEF = 6;

  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned STEP_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [STEP_W-1:0] RING_STEP_RST    = 8'd2;
  localparam logic [STEP_W-1:0] PATTERN_STEP_RST = 8'd20;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK         = 3'd0,
    FUNC_START_PAT    = 3'd1,
    FUNC_START_RING   = 3'd2,
    FUNC_CLEAR_EVENTS = 3'd3,
    FUNC_LOAD_COUNT   = 3'd4,
    FUNC_LOAD_ELAPSED = 3'd5
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_STEP    = 1'b0,
    CFG_PATTERN_STEP = 1'b1
  } cfg_idx_e;

  // odd-divisor test: y % d == 0 iff (y * d^-1 mod 2^n) <= (2^n - 1) / d
  localparam logic [14:0] INV5_15  = 15'h4CCD;
  localparam logic [14:0] LIM5_15  = 15'd6553;
  localparam logic [13:0] INV25_14 = 14'd7209;
  localparam logic [13:0] LIM25_14 = 14'd655;

  // x % 10 == 0 : even, and x/2 a multiple of 5
  function automatic logic is_mult10(input logic [COUNT_W-1:0] x);
    logic [14:0] prod;
    begin
      prod = x[15:1] * INV5_15;
      return (x[0] == 1'b0) && (prod <= LIM5_15);
    end
  endfunction

  // x % 100 == 0 : multiple of 4, and x/4 a multiple of 25
  function automatic logic is_mult100(input logic [COUNT_W-1:0] x);
    logic [13:0] prod;
    begin
      prod = x[15:2] * INV25_14;
      return (x[1:0] == 2'b00) && (prod <= LIM25_14);
    end
  endfunction

endpackage

FILE: src/tick_key_qualifier_buzzer.sv
// tick_key_qualifier_buzzer: 10 ms tick engine with elapsed / countdown counters,
// button qualifier and buzzer sequencer.
// Depends on tkqb_pkg.

// One word is taken per clock cycle and its result word appears on the master
// side on the next cycle; while the master side stalls, a new word is taken in
// the same cycle that the waiting result leaves, so the sustained rate is one
// word per cycle, set by the single result register. func on tuser selects a
// tick or a command. A tick advances the wrapping elapsed counter, counts a
// nonzero countdown down, samples the buttons (two pressed ticks in a row set
// a sticky event, a release re-arms) and steps the buzzer: ring steps come
// before pattern bits, each held for the configured step count plus one tick.
// display_due pulses on a tick where the tour runs and elapsed is a multiple of
// ten, or where the countdown reaches a multiple of one hundred. The user writes the two
// step registers through the cfg port only while no word is in flight; not enforced here.
module tick_key_qualifier_buzzer #(
  parameter int unsigned NUM_BUTTONS = tkqb_pkg::NUM_BUTTONS_DEF,
  localparam int unsigned IN_BITS  = NUM_BUTTONS + tkqb_pkg::VALUE_W + 1,
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = NUM_BUTTONS + 2 * tkqb_pkg::COUNT_W + 2,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // buttons, value, tour_running
  input  logic [IN_W-1:0]                     s_axis_tdata,
  // func
  input  logic [tkqb_pkg::FUNC_W-1:0]         s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // buzzer_on, key_events, elapsed_ticks, countdown_left, display_due
  output logic [OUT_W-1:0]                    m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic [tkqb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tkqb_pkg::STEP_W-1:0]         cfg_wdata_i
);
  import tkqb_pkg::*;

  logic [STEP_W-1:0]      ring_step_q, pattern_step_q;
  logic [COUNT_W-1:0]     elapsed_q, elapsed_d;
  logic [COUNT_W-1:0]     countdown_q, countdown_d;
  logic [NUM_BUTTONS-1:0] stable_q, stable_d;
  logic [NUM_BUTTONS-1:0] sample_q, sample_d;
  logic [NUM_BUTTONS-1:0] pending_q, pending_d;
  logic [STEP_W-1:0]      hold_q, hold_d;
  logic [STEP_W-1:0]      ring_left_q, ring_left_d;
  logic [STEP_W-1:0]      pattern_q, pattern_d;
  logic                   buzzer_q, buzzer_d;
  logic                   due_q, due_d;
  logic                   out_valid_q;

  logic                   in_accept;
  func_e                  func;
  logic [NUM_BUTTONS-1:0] buttons;
  logic [VALUE_W-1:0]     value;
  logic                   tour;
  logic [NUM_BUTTONS-1:0] diff, hit, arm, rel;

  assign func    = func_e'(s_axis_tuser);
  assign buttons = s_axis_tdata[NUM_BUTTONS-1:0];
  assign value   = s_axis_tdata[NUM_BUTTONS +: VALUE_W];
  assign tour    = s_axis_tdata[NUM_BUTTONS + VALUE_W];

  // state regs hold the latest result, so they can only move once it is taken
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign diff = stable_q ^ sample_q;
  assign hit  = buttons & diff;
  assign arm  = buttons & ~diff;
  assign rel  = ~buttons;

  always_comb begin
    elapsed_d   = elapsed_q;
    countdown_d = countdown_q;
    stable_d    = stable_q;
    sample_d    = sample_q;
    pending_d   = pending_q;
    hold_d      = hold_q;
    ring_left_d = ring_left_q;
    pattern_d   = pattern_q;
    buzzer_d    = buzzer_q;
    due_d       = 1'b0;
    case (func)
      FUNC_TICK: begin
        elapsed_d = elapsed_q + 1'b1;
        if (tour && is_mult10(elapsed_d)) begin
          due_d = 1'b1;
        end
        if (countdown_q != '0) begin
          countdown_d = countdown_q - 1'b1;
          if (is_mult100(countdown_d)) begin
            due_d = 1'b1;
          end
        end
        stable_d  = (stable_q | hit) & ~rel;
        sample_d  = (sample_q | arm) & ~rel;
        pending_d = pending_q | hit;
        // ring has priority over pattern
        if (hold_q != '0) begin
          hold_d = hold_q - 1'b1;
        end else if (ring_left_q != '0) begin
          hold_d      = ring_step_q;
          buzzer_d    = ring_left_q[0];
          ring_left_d = ring_left_q - 1'b1;
        end else if (pattern_q != '0) begin
          hold_d    = pattern_step_q;
          buzzer_d  = pattern_q[0];
          pattern_d = pattern_q >> 1;
        end else begin
          buzzer_d = 1'b0;
        end
      end
      FUNC_START_PAT: begin
        pattern_d = value[STEP_W-1:0];
        buzzer_d  = 1'b1;
        hold_d    = pattern_step_q;
      end
      FUNC_START_RING: begin
        ring_left_d = value[STEP_W-1:0];
        buzzer_d    = 1'b1;
        hold_d      = ring_step_q;
      end
      FUNC_CLEAR_EVENTS: begin
        pending_d = pending_q & ~value[NUM_BUTTONS-1:0];
      end
      FUNC_LOAD_COUNT: begin
        countdown_d = value;
      end
      FUNC_LOAD_ELAPSED: begin
        elapsed_d = value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_step_q    <= RING_STEP_RST;
      pattern_step_q <= PATTERN_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RING_STEP:    ring_step_q    <= cfg_wdata_i;
        CFG_PATTERN_STEP: pattern_step_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= '0;
      countdown_q <= '0;
      stable_q    <= '0;
      sample_q    <= '0;
      pending_q   <= '0;
      hold_q      <= '0;
      ring_left_q <= '0;
      pattern_q   <= '0;
      buzzer_q    <= 1'b0;
      due_q       <= 1'b0;
    end else if (in_accept) begin
      elapsed_q   <= elapsed_d;
      countdown_q <= countdown_d;
      stable_q    <= stable_d;
      sample_q    <= sample_d;
      pending_q   <= pending_d;
      hold_q      <= hold_d;
      ring_left_q <= ring_left_d;
      pattern_q   <= pattern_d;
      buzzer_q    <= buzzer_d;
      due_q       <= due_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({due_q, countdown_q, elapsed_q, pending_q, buzzer_q});

  // a result word is always ready to leave the cycle after a word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> m_axis_tvalid)
    else $error("no result word after accepted input");

  // display pulse only ever comes from a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (func != FUNC_TICK) |=> !due_q)
    else $error("display_due raised by a non-tick command");

  // elapsed load lands exactly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (func == FUNC_LOAD_ELAPSED) |=> elapsed_q == $past(value))
    else $error("elapsed load value lost");

  // an empty result slot never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result slot");

endmodule

FILE: dv/tick_key_qualifier_buzzer_test.sv
// tick_key_qualifier_buzzer_test: self-checking bench for the tick / key / buzzer block,
// with a queue-fed stream driver, a result monitor and its own predictor of the engine.
// Depends on tkqb_pkg and tick_key_qualifier_buzzer.
module tick_key_qualifier_buzzer_test;
  import tkqb_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;
  localparam int WORDS_PER_PHASE = 470;
  localparam int LONG_STALL_CYCLES = 300;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [5:0]        buttons;
    logic [15:0]       value;
    logic              tour;
  } key_word_t;

  typedef struct {
    logic        buzzer_on;
    logic [5:0]  key_events;
    logic [15:0] elapsed;
    logic [15:0] countdown;
    logic        display_due;
  } tick_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [23:0] s_axis_tdata = '0;
  logic [FUNC_W-1:0] s_axis_tuser = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [STEP_W-1:0]    cfg_wdata_i = '0;

  key_word_t    pending_words[$];
  tick_report_t expected_reports[$];
  int  mismatch_count = 0;
  bit  word_taken = 1'b0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  stall_requests = 0;
  int  stall_served = 0;
  int  stall_left = 0;
  logic [5:0] held_buttons = '0;

  // predictor copy of the block state and step registers
  logic [7:0]  ring_step_q = RING_STEP_RST;
  logic [7:0]  pattern_step_q = PATTERN_STEP_RST;
  logic [15:0] elapsed_q = '0;
  logic [15:0] countdown_q = '0;
  logic [5:0]  key_stable_q = '0;
  logic [5:0]  key_sample_q = '0;
  logic [5:0]  key_pending_q = '0;
  logic [7:0]  hold_q = '0;
  logic [7:0]  ring_left_q = '0;
  logic [7:0]  pattern_q = '0;
  logic        buzz_q = 1'b0;

  tick_key_qualifier_buzzer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic tick_report_t advance_engine(input key_word_t w);
    tick_report_t r;
    logic [5:0] diff;
    logic [5:0] hit;
    logic [5:0] arm;
    r.display_due = 1'b0;
    case (w.func)
      FUNC_TICK: begin
        elapsed_q = elapsed_q + 16'd1;
        if (w.tour && (elapsed_q % 10) == 0) r.display_due = 1'b1;
        if (countdown_q != 0) begin
          countdown_q = countdown_q - 16'd1;
          if ((countdown_q % 100) == 0) r.display_due = 1'b1;
        end
        // second pressed sample in a row qualifies; a release clears both
        diff = key_stable_q ^ key_sample_q;
        hit = w.buttons & diff;
        arm = w.buttons & ~diff;
        key_stable_q = (key_stable_q | hit) & w.buttons;
        key_pending_q = key_pending_q | hit;
        key_sample_q = (key_sample_q | arm) & w.buttons;
        if (hold_q != 0) begin
          hold_q = hold_q - 8'd1;
        end else if (ring_left_q != 0) begin
          hold_q = ring_step_q;
          buzz_q = ring_left_q[0];
          ring_left_q = ring_left_q - 8'd1;
        end else if (pattern_q != 0) begin
          hold_q = pattern_step_q;
          buzz_q = pattern_q[0];
          pattern_q = pattern_q >> 1;
        end else begin
          buzz_q = 1'b0;
        end
      end
      FUNC_START_PAT: begin
        pattern_q = w.value[7:0];
        buzz_q = 1'b1;
        hold_q = pattern_step_q;
      end
      FUNC_START_RING: begin
        ring_left_q = w.value[7:0];
        buzz_q = 1'b1;
        hold_q = ring_step_q;
      end
      FUNC_CLEAR_EVENTS: key_pending_q = key_pending_q & ~w.value[5:0];
      FUNC_LOAD_COUNT: countdown_q = w.value;
      FUNC_LOAD_ELAPSED: elapsed_q = w.value;
      default: ;
    endcase
    r.buzzer_on = buzz_q;
    r.key_events = key_pending_q;
    r.elapsed = elapsed_q;
    r.countdown = countdown_q;
    return r;
  endfunction

  task automatic check_field(input string label, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
    end
  endtask

  // monitor first, then prediction: a result is registered, so it never leaves as its word is taken
  always @(posedge clk_i) begin
    tick_report_t want;
    word_taken = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RING_STEP:    ring_step_q = cfg_wdata_i;
          CFG_PATTERN_STEP: pattern_step_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result word, expected none, actual %0h", $time,
                   m_axis_tdata);
        end else begin
          want = expected_reports.pop_front();
          check_field("buzzer_on", 16'(want.buzzer_on), 16'(m_axis_tdata[0]));
          check_field("key_events", 16'(want.key_events), 16'(m_axis_tdata[6:1]));
          check_field("elapsed_ticks", want.elapsed, m_axis_tdata[22:7]);
          check_field("countdown_left", want.countdown, m_axis_tdata[38:23]);
          check_field("display_due", 16'(want.display_due), 16'(m_axis_tdata[39]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        word_taken = 1'b1;
        expected_reports.push_back(advance_engine(key_word_t'{
          func: s_axis_tuser, buttons: s_axis_tdata[5:0],
          value: s_axis_tdata[21:6], tour: s_axis_tdata[22]}));
      end
    end
  end

  always @(negedge clk_i) begin
    key_word_t w;
    if (rst_ni && (!s_axis_tvalid || word_taken)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        s_axis_tdata <= {1'b0, w.tour, w.value, w.buttons};
        s_axis_tuser <= w.func;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_served != stall_requests) begin
      stall_served++;
      stall_left = LONG_STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_word(input logic [FUNC_W-1:0] func, input logic [5:0] buttons,
                            input logic [15:0] value, input logic tour);
    pending_words.push_back(key_word_t'{func: func, buttons: buttons, value: value,
                                        tour: tour});
  endtask

  task automatic queue_random_word();
    int pick;
    logic [15:0] value;
    logic [FUNC_W-1:0] func;
    logic [2:0] bit_idx;
    pick = $urandom_range(99);
    value = 16'($urandom);
    // buttons mostly hold their level so presses get qualified
    if ($urandom_range(9) < 3) begin
      bit_idx = 3'($urandom_range(5));
      held_buttons[bit_idx] = ~held_buttons[bit_idx];
    end
    if ($urandom_range(19) == 0) held_buttons = 6'($urandom);
    if (pick < 72) begin
      func = FUNC_TICK;
    end else if (pick < 78) begin
      func = FUNC_START_PAT;
    end else if (pick < 84) begin
      func = FUNC_START_RING;
      if ($urandom_range(3) != 0) value[7:0] = 8'($urandom_range(8));
    end else if (pick < 89) begin
      func = FUNC_CLEAR_EVENTS;
    end else if (pick < 94) begin
      func = FUNC_LOAD_COUNT;
      if ($urandom_range(3) != 0) value = 16'($urandom_range(250));
    end else if (pick < 98) begin
      func = FUNC_LOAD_ELAPSED;
      if ($urandom_range(1) != 0) value = 16'hFFFF - 16'($urandom_range(20));
    end else begin
      func = $urandom_range(1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
    end
    queue_word(func, held_buttons, value, $urandom_range(3) != 0);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    #1;
    while (pending_words.size() != 0 || (s_axis_tvalid && !word_taken) ||
           expected_reports.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
  endtask

  task automatic write_step_regs(input logic [7:0] ring_step, input logic [7:0] pattern_step);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_RING_STEP;
    cfg_wdata_i <= ring_step;
    @(negedge clk_i);
    cfg_idx_i <= CFG_PATTERN_STEP;
    cfg_wdata_i <= pattern_step;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [7:0] ring_steps[4];
    logic [7:0] pattern_steps[4];
    ring_steps = '{8'd0, 8'd255, 8'd1, 8'd7};
    pattern_steps = '{8'd0, 8'd255, 8'd3, 8'd0};
    send_idle_pct = 33;
    recv_idle_pct = 76;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: counter wrap, display conditions, keys, buzzer, spare codes
    queue_word(FUNC_TICK, 6'h00, 16'h0000, 1'b0);
    queue_word(FUNC_LOAD_ELAPSED, 6'h00, 16'hFFFF, 1'b0);
    queue_word(FUNC_TICK, 6'h00, 16'h0000, 1'b1);
    queue_word(FUNC_LOAD_COUNT, 6'h00, 16'd101, 1'b0);
    queue_word(FUNC_TICK, 6'h00, 16'h0000, 1'b0);
    queue_word(FUNC_TICK, 6'h00, 16'h0000, 1'b0);
    queue_word(FUNC_LOAD_COUNT, 6'h00, 16'd1, 1'b0);
    queue_word(FUNC_TICK, 6'h00, 16'h0000, 1'b0);
    queue_word(FUNC_TICK, 6'h00, 16'h0000, 1'b1);
    queue_word(FUNC_TICK, 6'h3F, 16'h0000, 1'b0);
    queue_word(FUNC_TICK, 6'h3F, 16'h0000, 1'b0);
    queue_word(FUNC_TICK, 6'h00, 16'h0000, 1'b0);
    queue_word(FUNC_CLEAR_EVENTS, 6'h3F, 16'hFFD5, 1'b1);
    queue_word(FUNC_START_PAT, 6'h00, 16'hFF55, 1'b0);
    queue_word(FUNC_START_RING, 6'h00, 16'hAB03, 1'b0);
    repeat (4) queue_word(FUNC_TICK, 6'h00, 16'h0000, 1'b0);
    queue_word(FUNC_CLEAR_EVENTS, 6'h00, 16'hFFFF, 1'b0);
    queue_word(FUNC_SPARE_6, 6'h3F, 16'hFFFF, 1'b1);
    queue_word(FUNC_SPARE_7, 6'h15, 16'h5A5A, 1'b1);
    queue_word(FUNC_START_PAT, 6'h00, 16'hFF00, 1'b0);
    queue_word(FUNC_LOAD_COUNT, 6'h00, 16'hFFFF, 1'b0);
    queue_word(FUNC_TICK, 6'h2A, 16'hFFFF, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      write_step_regs(ring_steps[phase], pattern_steps[phase]);
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 76 : 0;
      recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 33 : 0;
      repeat (WORDS_PER_PHASE) queue_random_word();
      // receiver stops for a long stretch while the sender keeps offering
      if (phase == 2) stall_requests++;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
